// ===== src/three_channel_limit_alarm_reporter_assert.svh =====
// assertion macros used by the checker file
`ifndef THREE_CHANNEL_LIMIT_ALARM_REPORTER_ASSERT_SVH
`define THREE_CHANNEL_LIMIT_ALARM_REPORTER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TCLAR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TCLAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tclar_pkg.sv =====
`timescale 1ns / 1ps
package tclar_pkg;

  // field widths
  localparam int unsigned TEMP_W   = 15;
  localparam int unsigned THYST_W  = 13;
  localparam int unsigned PH_W     = 11;
  localparam int unsigned SAL_W    = 14;
  localparam int unsigned REASON_W = 3;
  localparam int unsigned FLAG_N   = 5;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // flag bit positions
  localparam int unsigned FLG_TEMP_HIGH = 0;
  localparam int unsigned FLG_PH_LOW    = 1;
  localparam int unsigned FLG_PH_HIGH   = 2;
  localparam int unsigned FLG_SAL_LOW   = 3;
  localparam int unsigned FLG_SAL_HIGH  = 4;

  // register reset values
  localparam logic signed [TEMP_W-1:0] TEMP_MAX_RST  = 15'sd2500;
  localparam logic [THYST_W-1:0]       TEMP_HYST_RST = 13'd500;
  localparam logic [PH_W-1:0]          PH_MIN_RST    = 11'd280;
  localparam logic [PH_W-1:0]          PH_MAX_RST    = 11'd300;
  localparam logic [PH_W-1:0]          PH_HYST_RST   = 11'd10;
  localparam logic [SAL_W-1:0]         SAL_MIN_RST   = 14'd200;
  localparam logic [SAL_W-1:0]         SAL_MAX_RST   = 14'd300;
  localparam logic [SAL_W-1:0]         SAL_HYST_RST  = 14'd50;

  // skip counter terminal counts
  localparam logic [1:0] SKIP_NORM_LAST = 2'd3;
  localparam logic [1:0] SKIP_WARN_LAST = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_MAX  = 3'd0,
    CFG_TEMP_HYST = 3'd1,
    CFG_PH_MIN    = 3'd2,
    CFG_PH_MAX    = 3'd3,
    CFG_PH_HYST   = 3'd4,
    CFG_SAL_MIN   = 3'd5,
    CFG_SAL_MAX   = 3'd6,
    CFG_SAL_HYST  = 3'd7
  } cfg_idx_e;

  typedef enum logic [REASON_W-1:0] {
    RSN_NONE      = 3'd0,
    RSN_FIRST     = 3'd1,
    RSN_ALARM_IN  = 3'd2,
    RSN_ALARM_CLR = 3'd3,
    RSN_WARN_PER  = 3'd4,
    RSN_NORM_PER  = 3'd5
  } reason_e;

  typedef logic [FLAG_N-1:0] flags_t;

endpackage

// ===== src/tclar_in_if.sv =====
`timescale 1ns / 1ps
interface tclar_in_if;
  import tclar_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [TEMP_W-1:0] temp_sample;
  logic [PH_W-1:0]          ph_sample;
  logic [SAL_W-1:0]         sal_sample;

  modport source (output valid, cmd, temp_sample, ph_sample, sal_sample, input ready);
  modport sink   (input valid, cmd, temp_sample, ph_sample, sal_sample, output ready);
endinterface

// ===== src/tclar_out_if.sv =====
`timescale 1ns / 1ps
interface tclar_out_if;
  import tclar_pkg::*;

  logic                valid;
  logic                ready;
  logic                report;
  logic [REASON_W-1:0] report_reason;
  logic                warning_active;
  logic                temp_high_flag;
  logic                ph_low_flag;
  logic                ph_high_flag;
  logic                sal_low_flag;
  logic                sal_high_flag;

  modport source (output valid, report, report_reason, warning_active, temp_high_flag,
                  ph_low_flag, ph_high_flag, sal_low_flag, sal_high_flag, input ready);
  modport sink   (input valid, report, report_reason, warning_active, temp_high_flag,
                  ph_low_flag, ph_high_flag, sal_low_flag, sal_high_flag, output ready);
endinterface

// ===== src/three_channel_limit_alarm_reporter.sv =====
`timescale 1ns / 1ps
// channel   dir  contents
// smp_i     in   cmd, temp_sample, ph_sample, sal_sample
// res_o     out  report, report_reason, warning_active, five alarm flags
// cfg_*     in   write enable, register index, write data (no read-back)
//
// one word per cycle in, one result word per cycle out, while res_o is not stalled;
// res_o.valid rises in the cycle after accept, set by the single result register
// the result register frees itself in the cycle res_o.ready takes it, so a
// stalled output blocks input only while that one register is full
// rst_ni clears warning, flags and skip count, arms the first report and
// loads the register defaults
module three_channel_limit_alarm_reporter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tclar_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tclar_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  tclar_in_if.sink                          smp_i,
  tclar_out_if.source                       res_o
);
  import tclar_pkg::*;

  // configuration registers
  logic signed [TEMP_W-1:0] temp_max_q;
  logic [THYST_W-1:0]       temp_hyst_q;
  logic [PH_W-1:0]          ph_min_q, ph_max_q, ph_hyst_q;
  logic [SAL_W-1:0]         sal_min_q, sal_max_q, sal_hyst_q;

  // block state
  logic       warn_q, warn_d;
  flags_t     flags_q, flags_d;
  logic [1:0] skip_q, skip_d;
  logic       first_q, first_d;
  reason_e    reason_d;

  // result register
  logic    out_vld_q;
  logic    out_warn_q;
  flags_t  out_flags_q;
  reason_e out_reason_q;

  logic accept;

  // extended operands for the compares
  logic signed [TEMP_W+1:0] t_ext, tmax_ext, t_clr_lim;
  logic signed [PH_W+1:0]   ph_hi_lim;
  logic [PH_W:0]            ph_lo_lim;
  logic signed [SAL_W+1:0]  sal_hi_lim;
  logic [SAL_W:0]           sal_lo_lim;
  flags_t                   flg_set, flg_clr;

  assign accept      = smp_i.valid && smp_i.ready;
  assign smp_i.ready = !out_vld_q || res_o.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_max_q  <= TEMP_MAX_RST;
      temp_hyst_q <= TEMP_HYST_RST;
      ph_min_q    <= PH_MIN_RST;
      ph_max_q    <= PH_MAX_RST;
      ph_hyst_q   <= PH_HYST_RST;
      sal_min_q   <= SAL_MIN_RST;
      sal_max_q   <= SAL_MAX_RST;
      sal_hyst_q  <= SAL_HYST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TEMP_MAX:  temp_max_q  <= cfg_data_i[TEMP_W-1:0];
        CFG_TEMP_HYST: temp_hyst_q <= cfg_data_i[THYST_W-1:0];
        CFG_PH_MIN:    ph_min_q    <= cfg_data_i[PH_W-1:0];
        CFG_PH_MAX:    ph_max_q    <= cfg_data_i[PH_W-1:0];
        CFG_PH_HYST:   ph_hyst_q   <= cfg_data_i[PH_W-1:0];
        CFG_SAL_MIN:   sal_min_q   <= cfg_data_i[SAL_W-1:0];
        CFG_SAL_MAX:   sal_max_q   <= cfg_data_i[SAL_W-1:0];
        CFG_SAL_HYST:  sal_hyst_q  <= cfg_data_i[SAL_W-1:0];
      endcase
    end
  end

  // clear thresholds, exact in widened arithmetic
  assign t_ext      = {{2{smp_i.temp_sample[TEMP_W-1]}}, smp_i.temp_sample};
  assign tmax_ext   = {{2{temp_max_q[TEMP_W-1]}}, temp_max_q};
  assign t_clr_lim  = tmax_ext - $signed({4'b0, temp_hyst_q});
  assign ph_lo_lim  = {1'b0, ph_min_q} + {1'b0, ph_hyst_q};
  assign ph_hi_lim  = $signed({2'b0, ph_max_q}) - $signed({2'b0, ph_hyst_q});
  assign sal_lo_lim = {1'b0, sal_min_q} + {1'b0, sal_hyst_q};
  assign sal_hi_lim = $signed({2'b0, sal_max_q}) - $signed({2'b0, sal_hyst_q});

  // limit checks while normal, low wins over high
  always_comb begin
    flg_set = '0;
    flg_set[FLG_TEMP_HIGH] = t_ext > tmax_ext;
    flg_set[FLG_PH_LOW]    = smp_i.ph_sample < ph_min_q;
    flg_set[FLG_PH_HIGH]   = !flg_set[FLG_PH_LOW] && (smp_i.ph_sample > ph_max_q);
    flg_set[FLG_SAL_LOW]   = smp_i.sal_sample < sal_min_q;
    flg_set[FLG_SAL_HIGH]  = !flg_set[FLG_SAL_LOW] && (smp_i.sal_sample > sal_max_q);
  end

  // hysteresis clear conditions while in warning
  always_comb begin
    flg_clr = '0;
    flg_clr[FLG_TEMP_HIGH] = t_ext <= t_clr_lim;
    flg_clr[FLG_PH_LOW]    = {1'b0, smp_i.ph_sample} >= ph_lo_lim;
    flg_clr[FLG_PH_HIGH]   = $signed({2'b0, smp_i.ph_sample}) <= ph_hi_lim;
    flg_clr[FLG_SAL_LOW]   = {1'b0, smp_i.sal_sample} >= sal_lo_lim;
    flg_clr[FLG_SAL_HIGH]  = $signed({2'b0, smp_i.sal_sample}) <= sal_hi_lim;
  end

  // next state and report decision
  always_comb begin
    warn_d   = warn_q;
    flags_d  = flags_q;
    skip_d   = skip_q;
    first_d  = first_q;
    reason_d = RSN_NONE;
    if (smp_i.cmd) begin
      warn_d  = 1'b0;
      flags_d = '0;
      skip_d  = '0;
      first_d = 1'b1;
    end else if (!warn_q) begin
      flags_d = flg_set;
      priority if (flg_set != '0) begin
        reason_d = RSN_ALARM_IN;
        warn_d   = 1'b1;
        skip_d   = '0;
      end else if (first_q) begin
        reason_d = RSN_FIRST;
        first_d  = 1'b0;
      end else if (skip_q == SKIP_NORM_LAST) begin
        reason_d = RSN_NORM_PER;
        skip_d   = '0;
      end else begin
        skip_d = skip_q + 2'd1;
      end
    end else begin
      flags_d = flags_q & ~flg_clr;
      priority if (flags_d == '0) begin
        reason_d = RSN_ALARM_CLR;
        warn_d   = 1'b0;
        skip_d   = '0;
      end else if (skip_q == SKIP_WARN_LAST) begin
        reason_d = RSN_WARN_PER;
        skip_d   = '0;
      end else begin
        skip_d = skip_q + 2'd1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_q  <= 1'b0;
      flags_q <= '0;
      skip_q  <= '0;
      first_q <= 1'b1;
    end else if (accept) begin
      warn_q  <= warn_d;
      flags_q <= flags_d;
      skip_q  <= skip_d;
      first_q <= first_d;
    end
  end

  // result word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_warn_q   <= warn_d;
      out_flags_q  <= flags_d;
      out_reason_q <= reason_d;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.report         = out_reason_q != RSN_NONE;
  assign res_o.report_reason  = out_reason_q;
  assign res_o.warning_active = out_warn_q;
  assign res_o.temp_high_flag = out_flags_q[FLG_TEMP_HIGH];
  assign res_o.ph_low_flag    = out_flags_q[FLG_PH_LOW];
  assign res_o.ph_high_flag   = out_flags_q[FLG_PH_HIGH];
  assign res_o.sal_low_flag   = out_flags_q[FLG_SAL_LOW];
  assign res_o.sal_high_flag  = out_flags_q[FLG_SAL_HIGH];

endmodule

// ===== src/tclar_checker.sv =====
`timescale 1ns / 1ps
`include "three_channel_limit_alarm_reporter_assert.svh"
module tclar_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_cmd_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             out_report_i,
  input logic                             out_warning_i,
  input logic [tclar_pkg::REASON_W-1:0]   out_reason_i
);
  import tclar_pkg::*;

  logic in_acc;
  logic res_quiet;
  logic out_stall;

  // handshake and result terms
  assign in_acc    = in_valid_i && in_ready_i;
  assign res_quiet = !out_report_i && !out_warning_i && (out_reason_i == RSN_NONE);
  assign out_stall = out_valid_i && !out_ready_i;

  // every accepted word shows up as a result the next cycle
  `TCLAR_ASSERT_NEXT(a_accept_gives_result, in_acc, out_valid_i, "no result after accept")

  // a restart reports nothing and leaves warning
  `TCLAR_ASSERT_NEXT(a_restart_quiet, in_acc && in_cmd_i, res_quiet, "restart not cleared")

  // an empty result register never blocks input
  `TCLAR_ASSERT_IMPL(a_ready_when_empty, !out_valid_i, in_ready_i, "stall while empty")

  // a stalled result holds
  `TCLAR_ASSERT_NEXT(a_stall_hold, out_stall, out_valid_i && $stable(out_reason_i), "stall lost")

endmodule

bind three_channel_limit_alarm_reporter tclar_checker u_tclar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (smp_i.valid),
  .in_ready_i    (smp_i.ready),
  .in_cmd_i      (smp_i.cmd),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .out_report_i  (res_o.report),
  .out_warning_i (res_o.warning_active),
  .out_reason_i  (res_o.report_reason)
);
